/* design/dbbvs_pkg.sv */
// Shared types and constants of the double-buffered variable store.
`default_nettype none

package dbbvs_pkg;

  localparam int DEF_VARIABLES = 16;
  localparam int DEF_MAX_BYTES = 16;

  localparam int LEN_W       = 5;
  localparam int VAR_FIELD_W = 8;
  localparam int POS_FIELD_W = 6;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 16;
  localparam int OUT_USER_W  = 2;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_COMMIT  = 3'd1,
    CMD_READ    = 3'd2,
    CMD_COMPARE = 3'd3,
    CMD_TEST    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_COMPARE = 2'd1,
    KIND_TEST    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    COND_ZERO    = 3'd0,
    COND_NONZERO = 3'd1,
    COND_EVEN    = 3'd2,
    COND_ODD     = 3'd3
  } cond_e;

  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;
  localparam logic [1:0] ORDER_LESS    = 2'b11;

  typedef struct packed {
    cmd_e                   cmd;
    logic [VAR_FIELD_W-1:0] var_a;
    logic [VAR_FIELD_W-1:0] var_b;
    logic [POS_FIELD_W-1:0] pos;
    logic                   pos_ok;
    logic [7:0]             data;
    logic [LEN_W-1:0]       clen;
    logic [2:0]             cond;
  } cmd_t;

  typedef struct packed {
    logic             sel;
    logic [LEN_W-1:0] len1;
    logic [LEN_W-1:0] len0;
  } meta_t;

endpackage

`default_nettype wire

/* design/dbbvs_front.sv */
// Front end: accepts items, classifies them and queues the known commands.
`default_nettype none

module dbbvs_front import dbbvs_pkg::*; #(
  parameter int VARIABLES = DEF_VARIABLES,
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [IN_USER_W-1:0] s_axis_tuser_i,
  output logic                 q_valid_o,
  output cmd_t                 q_cmd_o,
  input  logic                 q_pop_i
);

  logic [VAR_FIELD_W-1:0] var_map [16];
  cmd_t                   entry;
  logic                   known;
  logic                   push;
  cmd_t                   q_mem [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q;

  for (genvar g = 0; g < 16; g++) begin : g_map
    assign var_map[g] = VAR_FIELD_W'(g % VARIABLES);
  end

  always_comb begin
    entry.cmd    = cmd_e'(s_axis_tuser_i);
    entry.var_a  = var_map[s_axis_tdata_i[3:0]];
    entry.var_b  = var_map[s_axis_tdata_i[7:4]];
    entry.pos    = POS_FIELD_W'(s_axis_tdata_i[11:8]);
    entry.pos_ok = {3'b000, s_axis_tdata_i[11:8]} < 7'(MAX_BYTES);
    entry.data   = s_axis_tdata_i[19:12];
    if ({2'b00, s_axis_tdata_i[24:20]} > 7'(MAX_BYTES)) begin
      entry.clen = LEN_W'(MAX_BYTES);
    end else begin
      entry.clen = s_axis_tdata_i[24:20];
    end
    entry.cond   = s_axis_tdata_i[27:25];
    case (cmd_e'(s_axis_tuser_i))
      CMD_WRITE, CMD_COMMIT, CMD_READ, CMD_COMPARE, CMD_TEST: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o && known;
  assign q_valid_o       = (cnt_q != 2'd0);
  assign q_cmd_o         = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dbbvs_back.sv */
// Back end: length table, byte store, command sequencer and result register.
`default_nettype none

module dbbvs_back import dbbvs_pkg::*; #(
  parameter int VARIABLES = DEF_VARIABLES,
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  cmd_t                  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int VW         = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;
  localparam int PW         = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int AW         = VW + 1 + PW;
  localparam int BYTE_DEPTH = 2 ** AW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_META,
    S_ADDR,
    S_DATA,
    S_EMIT
  } state_e;

  state_e                  state_q;
  cmd_t                    cmd_q;
  meta_t                   meta_mem [VARIABLES];
  meta_t                   meta_a_q, meta_b_q;
  logic [VARIABLES-1:0]    vld_q;
  logic [7:0]              byte_mem [BYTE_DEPTH];
  logic [7:0]              rd_a_q, rd_b_q;
  logic                    buf_a_q, buf_b_q;
  logic [LEN_W-1:0]        j_q, lim_q, da_q, db_q;
  logic                    any_q, par_q;
  logic [1:0]              order_q;
  logic                    tvalid_q;
  logic [OUT_DATA_W-1:0]   tdata_q;
  logic [OUT_USER_W-1:0]   tuser_q;
  logic                    tlast_q;

  logic [VW-1:0]           va, vb;
  meta_t                   row_a, row_b, new_row;
  logic [LEN_W-1:0]        len_a, len_b, lmax, j_nx;
  logic [PW-1:0]           pos_a, pos_b;
  logic                    in_a, in_b;
  logic [AW-1:0]           addr_a, addr_b, wr_addr;
  logic                    byte_we, meta_we;
  logic                    out_free, step_last, test_bit, emit;
  logic [7:0]              xa, xb;

  always_comb begin
    va        = cmd_q.var_a[VW-1:0];
    vb        = cmd_q.var_b[VW-1:0];
    row_a     = vld_q[va] ? meta_a_q : '0;
    row_b     = vld_q[vb] ? meta_b_q : '0;
    len_a     = row_a.sel ? row_a.len1 : row_a.len0;
    len_b     = row_b.sel ? row_b.len1 : row_b.len0;
    lmax      = (len_a > len_b) ? len_a : len_b;
    j_nx      = j_q + LEN_W'(1);
    step_last = (j_nx == lim_q);
    pos_a     = PW'(j_q - da_q);
    pos_b     = PW'(j_q - db_q);
    in_a      = (j_q >= da_q);
    in_b      = (j_q >= db_q);
    addr_a    = {va, buf_a_q, pos_a};
    addr_b    = {vb, buf_b_q, pos_b};
    wr_addr   = {va, ~row_a.sel, cmd_q.pos[PW-1:0]};
    byte_we   = (state_q == S_META) && (cmd_q.cmd == CMD_WRITE) && cmd_q.pos_ok;
    meta_we   = (state_q == S_META) && (cmd_q.cmd == CMD_COMMIT);
    new_row   = row_a;
    new_row.sel = ~row_a.sel;
    if (row_a.sel) begin
      new_row.len0 = cmd_q.clen;
    end else begin
      new_row.len1 = cmd_q.clen;
    end
    xa        = in_a ? rd_a_q : 8'h00;
    xb        = in_b ? rd_b_q : 8'h00;
    out_free  = !tvalid_q || m_axis_tready_i;
    emit      = out_free && ((state_q == S_EMIT) ||
                             ((state_q == S_DATA) && (cmd_q.cmd == CMD_READ)));
    case (cond_e'(cmd_q.cond))
      COND_ZERO:    test_bit = !any_q;
      COND_NONZERO: test_bit = any_q;
      COND_EVEN:    test_bit = !par_q;
      COND_ODD:     test_bit = par_q;
      default:      test_bit = 1'b0;
    endcase
  end

  assign q_pop_o         = (state_q == S_IDLE) && q_valid_i;
  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tlast_o  = tlast_q;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[va] <= new_row;
    end
    meta_a_q <= meta_mem[va];
    meta_b_q <= meta_mem[vb];
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[wr_addr] <= cmd_q.data;
    end
    rd_a_q <= byte_mem[addr_a];
    rd_b_q <= byte_mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= '0;
      vld_q    <= '0;
      buf_a_q  <= 1'b0;
      buf_b_q  <= 1'b0;
      j_q      <= '0;
      lim_q    <= '0;
      da_q     <= '0;
      db_q     <= '0;
      any_q    <= 1'b0;
      par_q    <= 1'b0;
      order_q  <= ORDER_EQUAL;
      tvalid_q <= 1'b0;
      tdata_q  <= '0;
      tuser_q  <= '0;
      tlast_q  <= 1'b0;
    end else begin
      if (emit) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q   <= q_cmd_i;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_META;
        end
        S_META: begin
          j_q     <= '0;
          buf_a_q <= row_a.sel;
          buf_b_q <= row_b.sel;
          da_q    <= (cmd_q.cmd == CMD_COMPARE) ? lmax - len_a : '0;
          db_q    <= (cmd_q.cmd == CMD_COMPARE) ? lmax - len_b : '0;
          any_q   <= 1'b0;
          par_q   <= 1'b0;
          order_q <= ORDER_EQUAL;
          case (cmd_q.cmd)
            CMD_COMMIT: begin
              vld_q[va] <= 1'b1;
              state_q   <= S_IDLE;
            end
            CMD_READ, CMD_TEST: begin
              lim_q   <= len_a;
              state_q <= (len_a == '0) ? S_EMIT : S_ADDR;
            end
            CMD_COMPARE: begin
              lim_q   <= lmax;
              state_q <= (lmax == '0) ? S_EMIT : S_ADDR;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_ADDR: begin
          state_q <= S_DATA;
        end
        S_DATA: begin
          case (cmd_q.cmd)
            CMD_READ: begin
              if (out_free) begin
                tuser_q  <= KIND_READ;
                tlast_q  <= step_last;
                tdata_q  <= {1'b0, ORDER_EQUAL, lim_q, rd_a_q};
                j_q      <= j_nx;
                state_q  <= step_last ? S_IDLE : S_ADDR;
              end
            end
            CMD_COMPARE: begin
              if (xa != xb) begin
                order_q <= (xa > xb) ? ORDER_GREATER : ORDER_LESS;
                state_q <= S_EMIT;
              end else if (step_last) begin
                state_q <= S_EMIT;
              end else begin
                j_q     <= j_nx;
                state_q <= S_ADDR;
              end
            end
            CMD_TEST: begin
              any_q   <= any_q | (rd_a_q != 8'h00);
              par_q   <= par_q ^ (^rd_a_q);
              j_q     <= j_nx;
              state_q <= step_last ? S_EMIT : S_ADDR;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) begin
            tlast_q  <= (cmd_q.cmd == CMD_READ);
            state_q  <= S_IDLE;
            case (cmd_q.cmd)
              CMD_READ: begin
                tuser_q <= KIND_READ;
                tdata_q <= '0;
              end
              CMD_COMPARE: begin
                tuser_q <= KIND_COMPARE;
                tdata_q <= {1'b0, order_q, {LEN_W{1'b0}}, 8'h00};
              end
              default: begin
                tuser_q <= KIND_TEST;
                tdata_q <= {test_bit, ORDER_EQUAL, {LEN_W{1'b0}}, 8'h00};
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/double_buffered_bignum_variable_store.sv */
// A write or commit takes effect in the sequencer's META state, after the queue, IDLE and FETCH;
// a read sends one byte per ADDR/DATA pass and waits in DATA while the output is stalled.
// A compare or test steps one stored byte per byte-store read, a compare to the longer visible
// length or first differing byte, a test to var_a's length; a two-entry queue takes items meanwhile.
// Reset clears the queue, the sequencer and the per-variable valid bits, so every length
// reads as zero at once; the byte store is not cleared and needs no clearing pass.
`default_nettype none

module double_buffered_bignum_variable_store import dbbvs_pkg::*; #(
  parameter int VARIABLES = DEF_VARIABLES,
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // var_a[3:0], var_b[7:4], byte_index[11:8], byte_in[19:12], commit_length[24:20],
  // condition[27:25], zero fill[31:28]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // byte_out[7:0], length_out[12:8], order[14:13], test_true[15]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind[1:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  dbbvs_front #(
    .VARIABLES(VARIABLES),
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_valid_o      (q_valid),
    .q_cmd_o        (q_cmd),
    .q_pop_i        (q_pop)
  );

  dbbvs_back #(
    .VARIABLES(VARIABLES),
    .MAX_BYTES(MAX_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
